// ===== design/b64enc_pkg.sv =====
// Shared types, constants and the alphabet function of the base64 line encoder.
// No dependencies; the front, queue, back and top-level files refer to it by scoped names.

package b64enc_pkg;

  localparam logic [7:0] NlChar             = 8'd10;
  localparam logic [7:0] PadChar            = 8'd61;
  localparam logic [5:0] GroupsPerLineReset = 6'd19;

  // character slots of one group job, in emission order
  typedef enum logic [2:0] {
    SlotNlBefore = 3'd0,
    SlotC0       = 3'd1,
    SlotC1       = 3'd2,
    SlotC2       = 3'd3,
    SlotC3       = 3'd4,
    SlotNlAfter  = 3'd5
  } slot_e;

  // configuration register index
  typedef enum logic {
    RegAppendEol     = 1'b0,
    RegGroupsPerLine = 1'b1
  } reg_e;

  // one group ready for emission, passed from front to back
  typedef struct packed {
    logic       nl_before;
    logic       eol_after;
    logic [1:0] nbytes;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } job_t;

  // standard base64 alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

// ===== design/b64enc_in_if.sv =====
// Input byte channel of the base64 line encoder: valid/ready plus payload.
// No dependencies.

interface b64enc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== design/b64enc_out_if.sv =====
// Output character channel of the base64 line encoder: valid/ready plus payload.
// No dependencies.

interface b64enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_end;

  modport source (output valid, output out_char, output run_end, input ready);
  modport sink   (input valid, input out_char, input run_end, output ready);
endinterface

// ===== design/b64enc_front.sv =====
// Front end: accepts bytes, gathers 3-byte groups, tracks line position, issues jobs.
// Depends on b64enc_pkg and b64enc_in_if.

module b64enc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  b64enc_in_if.sink           in_if,
  input  logic                append_eol_i,
  input  logic [5:0]          groups_per_line_i,
  input  logic                q_full_i,
  output logic                push_o,
  output b64enc_pkg::job_t    job_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  phase_q, phase_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        fire;
  logic        store_only;
  logic        nl_needed;

  assign in_if.ready = !q_full_i;
  assign fire        = in_if.valid && in_if.ready;
  assign store_only  = !in_if.final_byte && (phase_q != 2'd2);
  assign push_o      = fire && !store_only;
  assign nl_needed   = (cnt_q != 6'd0) && (cnt_q >= groups_per_line_i);

  always_comb begin
    job_o.nl_before = nl_needed;
    job_o.eol_after = in_if.final_byte && append_eol_i;
    job_o.nbytes    = phase_q + 2'd1;
    case (phase_q)
      2'd0: begin
        job_o.b1 = in_if.data_byte;
        job_o.b2 = 8'd0;
        job_o.b3 = 8'd0;
      end
      2'd1: begin
        job_o.b1 = held_q[7:0];
        job_o.b2 = in_if.data_byte;
        job_o.b3 = 8'd0;
      end
      default: begin
        job_o.b1 = held_q[15:8];
        job_o.b2 = held_q[7:0];
        job_o.b3 = in_if.data_byte;
      end
    endcase
  end

  always_comb begin
    held_d  = held_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (fire) begin
      if (store_only) begin
        held_d  = {held_q[7:0], in_if.data_byte};
        phase_d = phase_q + 2'd1;
      end else begin
        held_d  = 16'd0;
        phase_d = 2'd0;
        if (in_if.final_byte) begin
          cnt_d = 6'd0;
        end else if (nl_needed) begin
          cnt_d = 6'd1;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 16'd0;
      phase_q <= 2'd0;
      cnt_q   <= 6'd0;
    end else begin
      held_q  <= held_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("group phase reached three held bytes");

endmodule

// ===== design/b64enc_fifo.sv =====
// Two-entry job queue between front and back ends.
// Depends on b64enc_pkg.

module b64enc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64enc_pkg::job_t    job_i,
  input  logic                pop_i,
  output b64enc_pkg::job_t    job_o,
  output logic                full_o,
  output logic                empty_o
);

  b64enc_pkg::job_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from an empty queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

// ===== design/b64enc_back.sv =====
// Back end: takes one group job at a time and emits its characters one per cycle while the receiver is ready.
// Depends on b64enc_pkg and b64enc_out_if.

module b64enc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  b64enc_pkg::job_t    job_i,
  output logic                pop_o,
  b64enc_out_if.source        out_if
);

  logic                busy_q;
  b64enc_pkg::job_t    job_q;
  b64enc_pkg::slot_e   slot_q;
  b64enc_pkg::slot_e   last_slot;
  logic                fire;
  logic                done;
  logic [5:0]          sextet;
  logic                pad;
  logic                newline;

  assign last_slot = job_q.eol_after ? b64enc_pkg::SlotNlAfter : b64enc_pkg::SlotC3;
  assign fire      = out_if.valid && out_if.ready;
  assign done      = fire && (slot_q == last_slot);
  assign pop_o     = !q_empty_i && (!busy_q || done);

  always_comb begin
    sextet  = 6'd0;
    pad     = 1'b0;
    newline = 1'b0;
    unique case (slot_q) inside
      b64enc_pkg::SlotNlBefore, b64enc_pkg::SlotNlAfter: newline = 1'b1;
      b64enc_pkg::SlotC0: sextet = job_q.b1[7:2];
      b64enc_pkg::SlotC1: sextet = {job_q.b1[1:0], job_q.b2[7:4]};
      b64enc_pkg::SlotC2: begin
        sextet = {job_q.b2[3:0], job_q.b3[7:6]};
        pad    = (job_q.nbytes == 2'd1);
      end
      b64enc_pkg::SlotC3: begin
        sextet = job_q.b3[5:0];
        pad    = (job_q.nbytes != 2'd3);
      end
      default: newline = 1'b1;
    endcase
  end

  assign out_if.valid    = busy_q;
  assign out_if.run_end  = (slot_q == last_slot);
  assign out_if.out_char = newline ? b64enc_pkg::NlChar :
                           pad     ? b64enc_pkg::PadChar :
                                     b64enc_pkg::b64_char(sextet);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= b64enc_pkg::SlotC0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      slot_q <= job_i.nl_before ? b64enc_pkg::SlotNlBefore : b64enc_pkg::SlotC0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      slot_q <= b64enc_pkg::slot_e'(slot_q + 3'd1);
    end
  end

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !pop_o) |=> !busy_q)
    else $error("back end stayed busy after the last character");

endmodule

// ===== design/base64_line_wrapped_encoder.sv =====
// Top level of the base64 line encoder: APB registers and the front/queue/back chain.
// Depends on b64enc_pkg, b64enc_in_if, b64enc_out_if, b64enc_front, b64enc_fifo,
// b64enc_back.
//
// Usage: message bytes enter on in_if (valid/ready), final_byte set on the last one.
// Encoded characters leave on out_if, one per transfer; run_end marks the last
// character caused by an input byte (bytes that only fill a group cause none).
// Registers over APB: 0x0 append_eol (bit 0), 0x4 groups_per_line (bits 5:0).
// Write them only while the block is idle; reads return the stored values.
// With the back end idle, a group's job is written to the job queue when its last
// byte is taken, then loaded into the back end, which offers its first character.
// The output emits one character per cycle while the receiver is ready; input bytes
// are taken one per cycle while the two-entry job queue has room, so a sustained
// stream runs at the output rate of 4 characters per 3 bytes plus a newline per line.
// A final byte may yield up to six characters (newline, four, newline).
// Reset clears the group, line count and queue and loads append_eol = 0,
// groups_per_line = 19. When the receiver stalls, the current character holds
// and input is still taken until the job queue fills.

module base64_line_wrapped_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  b64enc_in_if.sink    in_if,
  b64enc_out_if.source out_if,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic             append_eol_q;
  logic [5:0]       gpl_q;
  logic             cfg_wr;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  b64enc_pkg::job_t job_in;
  b64enc_pkg::job_t job_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (b64enc_pkg::reg_e'(paddr[2]))
      b64enc_pkg::RegAppendEol:     prdata = {31'd0, append_eol_q};
      b64enc_pkg::RegGroupsPerLine: prdata = {26'd0, gpl_q};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_eol_q <= 1'b0;
      gpl_q        <= b64enc_pkg::GroupsPerLineReset;
    end else if (cfg_wr) begin
      unique case (b64enc_pkg::reg_e'(paddr[2]))
        b64enc_pkg::RegAppendEol:     append_eol_q <= pwdata[0];
        b64enc_pkg::RegGroupsPerLine: gpl_q        <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  b64enc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_if             (in_if),
    .append_eol_i      (append_eol_q),
    .groups_per_line_i (gpl_q),
    .q_full_i          (q_full),
    .push_o            (push),
    .job_o             (job_in)
  );

  b64enc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64enc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .job_i     (job_out),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule
